[sv/ipv4_descending_sorter_top_macros.svh]
// Assertion macros for the IPv4 descending sorter.
`ifndef IPV4_DESCENDING_SORTER_TOP_MACROS_SVH
`define IPV4_DESCENDING_SORTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, disabled in rst.
`define IPV4S_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk, disabled in rst.
`define IPV4S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IPV4S_ASSERT_NOW(lbl, ante, cons, msg)
`define IPV4S_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/ipv4s_pkg.sv]
// Shared types and constants for the IPv4 descending sorter.
`default_nettype none
package ipv4s_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int IP_W            = 32;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic [IP_W-1:0] addr;
    status_t         status;
  } result_t;

endpackage
`default_nettype wire

[sv/ipv4s_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ipv4s_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[sv/ipv4s_ctrl.sv]
// Push/pop sequencer: appends on push, scans the store for the maximum on pop.
`default_nettype none
module ipv4s_ctrl import ipv4s_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            action,
  input  wire logic [IP_W-1:0] address,
  output logic                 rd_en,
  output logic      [AW-1:0]   rd_addr,
  input  wire logic [IP_W-1:0] rd_data,
  output logic                 wr_en,
  output logic      [AW-1:0]   wr_addr,
  output logic      [IP_W-1:0] wr_data,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output result_t              res
);

  ctrl_state_t     state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   idx, idx_next;        // next entry to read
  logic [AW-1:0]   pend_idx, pend_next;  // entry whose data arrives this cycle
  logic [IP_W-1:0] best_val, best_val_next;
  logic [AW-1:0]   best_idx, best_idx_next;
  result_t         res_next;
  logic [IP_W-1:0] cand_val;
  logic [AW-1:0]   cand_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    pend_idx <= pend_next;
    best_val <= best_val_next;
    best_idx <= best_idx_next;
    res      <= res_next;
  end

  // running maximum; ties keep the earlier entry
  always_comb begin
    if (rd_data > best_val) begin
      cand_val = rd_data;
      cand_idx = pend_idx;
    end else begin
      cand_val = best_val;
      cand_idx = best_idx;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    pend_next     = pend_idx;
    best_val_next = best_val;
    best_idx_next = best_idx;
    res_next      = res;
    rd_en         = 1'b0;
    rd_addr       = idx[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = count[AW-1:0];
    wr_data       = address;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_RESP;
          if (action == ACT_PUSH) begin
            if (count == CW'(MAX_ENTRIES)) begin
              res_next = '{addr: '0, status: ST_FULL};
            end else begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
              res_next   = '{addr: '0, status: ST_OK};
            end
          end else if (count == '0) begin
            res_next = '{addr: '0, status: ST_EMPTY};
          end else begin
            rd_en         = 1'b1;
            rd_addr       = '0;
            pend_next     = '0;
            idx_next      = CW'(1);
            best_val_next = '0;
            best_idx_next = '0;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        best_val_next = cand_val;
        best_idx_next = cand_idx;
        if (idx < count) begin
          rd_en     = 1'b1;
          rd_addr   = idx[AW-1:0];
          pend_next = idx[AW-1:0];
          idx_next  = idx + CW'(1);
        end else begin
          // rd_data is the last entry: move it into the freed slot
          wr_en      = 1'b1;
          wr_addr    = cand_idx;
          wr_data    = rd_data;
          count_next = count - CW'(1);
          res_next   = '{addr: cand_val, status: ST_OK};
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[sv/ipv4_descending_sorter_top.sv]
// Top level of the IPv4 descending sorter: store RAM, sequencer, output register.
// Holds up to MAX_ENTRIES addresses in one RAM, unordered. A push appends at the
// fill count, then hands the result to the output register. On a pop of a
// non-empty store the sequencer reads the RAM one entry per cycle through its
// single read port to find the largest address, then writes the last entry into
// the freed slot. Pops on an empty store and pushes on a full one answer with
// status EMPTY or FULL and a zero address. Results sit in an output register, so
// the next beat is taken while one still waits downstream. The RAM needs no
// clearing after reset; only entries below the fill count are ever read.
`default_nettype none
`include "ipv4_descending_sorter_top_macros.svh"
module ipv4_descending_sorter_top import ipv4s_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            action,
  input  wire logic [IP_W-1:0] address,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic      [IP_W-1:0] address_out,
  output logic      [1:0]      status
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [IP_W-1:0] rd_data, wr_data;
  logic            res_valid, res_ready;
  result_t         res;

  ipv4s_ram #(
    .WIDTH (IP_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ipv4s_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .address   (address),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      address_out <= res.addr;
      status      <= res.status;
    end
  end

  `IPV4S_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "accepted while busy")
  `IPV4S_ASSERT_NOW(a_fail_zero_addr, out_valid && status != ST_OK, address_out == '0, "nonzero address on failure")
  `IPV4S_ASSERT_NOW(a_status_code, out_valid, status == ST_OK || status == ST_EMPTY || status == ST_FULL, "bad status code")

endmodule
`default_nettype wire
